/* hw/rtl/vector_normalize_assert.svh */
// assertion helpers, clocked on clk and disabled during reset
`ifndef VECTOR_NORMALIZE_ASSERT_SVH
`define VECTOR_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define VN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vector_normalize: check failed");

// next-cycle implication
`define VN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vector_normalize: check failed");

`endif

/* hw/rtl/vn_pkg.sv */
`default_nettype none
package vn_pkg;
	localparam int NFIELD = 6;
	localparam int DW     = 32;
	localparam int LW     = 33;
	localparam int SW     = 66;
	localparam int QW     = 31;
	localparam int ROOT_BITS = LW;

	typedef logic [NFIELD-1:0][DW-1:0] mag_vec_t;
	typedef logic [NFIELD-1:0][QW-1:0] quo_vec_t;

	typedef struct packed {
		mag_vec_t          mag;
		logic [NFIELD-1:0] neg;
	} side_t;

	typedef struct packed {
		quo_vec_t          quo;
		logic [NFIELD-1:0] neg;
		logic [LW-1:0]     len;
	} div_res_t;
endpackage
`default_nettype wire

/* hw/rtl/vn_sqrt.sv */
`default_nettype none
// pipelined integer square root, one root bit per stage
module vn_sqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [65:0]       in_sum,
	input  wire vn_pkg::side_t     in_side,
	output logic                   out_valid,
	output logic [32:0]            out_root,
	output vn_pkg::side_t          out_side
);
	import vn_pkg::*;

	localparam int RW = SW + 2;

	logic              v_s   [0:ROOT_BITS];
	logic [RW-1:0]     rem_s [0:ROOT_BITS];
	logic [LW-1:0]     root_s[0:ROOT_BITS];
	side_t             side_s[0:ROOT_BITS];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = {2'b0, in_sum};
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		localparam int B = ROOT_BITS - 1 - k;
		logic [RW-1:0] trial;
		logic          take;
		assign trial = ({{(RW-LW){1'b0}}, root_s[k]} << (B + 1)) | ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (rem_s[k] - trial) : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | ({{(LW-1){1'b0}}, 1'b1} << B)) : root_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_BITS];
	assign out_root  = root_s[ROOT_BITS];
	assign out_side  = side_s[ROOT_BITS];
endmodule
`default_nettype wire

/* hw/rtl/vn_div.sv */
`default_nettype none
// six-lane pipelined restoring divider, rounded quotient mag*2^30/len
module vn_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [32:0]       in_len,
	input  wire vn_pkg::side_t     in_side,
	output logic                   out_valid,
	output vn_pkg::div_res_t       out_res
);
	import vn_pkg::*;

	localparam int RW = SW;

	logic                          v_s  [0:QW];
	logic [NFIELD-1:0][RW-1:0]     r_s  [0:QW];
	quo_vec_t                      q_s  [0:QW];
	logic [NFIELD-1:0]             neg_s[0:QW];
	logic [LW-1:0]                 len_s[0:QW];

	assign v_s[0]   = in_valid;
	assign q_s[0]   = '0;
	assign neg_s[0] = in_side.neg;
	assign len_s[0] = in_len;
	for (genvar i = 0; i < NFIELD; i++) begin : g_init
		assign r_s[0][i] = ({{(RW-DW){1'b0}}, in_side.mag[i]} << QW) + {{(RW-LW){1'b0}}, in_len};
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [RW-1:0] dsh;
		assign dsh = {{(RW-LW-1){1'b0}}, len_s[j], 1'b0} << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		for (genvar i = 0; i < NFIELD; i++) begin : g_lane
			logic take;
			assign take = r_s[j][i] >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[j+1][i] <= take ? (r_s[j][i] - dsh) : r_s[j][i];
					q_s[j+1][i] <= take ? (q_s[j][i] | ({{(QW-1){1'b0}}, 1'b1} << K)) : q_s[j][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j+1] <= neg_s[j];
				len_s[j+1] <= len_s[j];
			end
		end
	end

	assign out_valid   = v_s[QW];
	assign out_res.quo = q_s[QW];
	assign out_res.neg = neg_s[QW];
	assign out_res.len = len_s[QW];
endmodule
`default_nettype wire

/* hw/rtl/vector_normalize.sv */
`default_nettype none
// Normalizes a vector of up to six signed Q16.16 deltas: returns each component
// divided by the Euclidean length as signed Q2.30 (rounded, halves away from zero)
// and the truncated length in unsigned Q17.16. An all-zero vector gives zero
// outputs and tuser set. Axes at index AXES and above are ignored and return zero.
// One item enters per cycle unless the pipe stalls. Stages: 4 square/sum,
// 33 square-root, 31 divider, then one output register. The whole pipe stalls
// while a result waits on m_tready.
module vector_normalize #(
	parameter int AXES = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [191:0] s_tdata,  // delta_0 .. delta_5, 32 bits each
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [231:0]      m_tdata,  // unit_0 .. unit_5 (32 each), length (33), pad
	output logic              m_tuser   // zero_vector
);
	import vn_pkg::*;

	localparam logic [QW-1:0] ONE_Q30 = {1'b1, {(QW-1){1'b0}}};

	logic en;
	logic out_v_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// s1: magnitudes
	logic     v_s1;
	side_t    side_s1;
	// s2: squares
	logic     v_s2;
	side_t    side_s2;
	logic [NFIELD-1:0][63:0] sq_s2;
	// s3: pair sums
	logic     v_s3;
	side_t    side_s3;
	logic [2:0][64:0] ps_s3;
	// s4: total
	logic     v_s4;
	side_t    side_s4;
	logic [65:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar i = 0; i < NFIELD; i++) begin : g_front
		logic [DW-1:0] d;
		assign d = s_tdata[i*DW +: DW];
		always_ff @(posedge clk) begin
			if (en) begin
				if (i < AXES) begin
					side_s1.mag[i] <= d[DW-1] ? (~d + 1'b1) : d;
					side_s1.neg[i] <= d[DW-1];
				end else begin
					side_s1.mag[i] <= '0;
					side_s1.neg[i] <= 1'b0;
				end
				sq_s2[i] <= {32'b0, side_s1.mag[i]} * {32'b0, side_s1.mag[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_s1;
			side_s3  <= side_s2;
			side_s4  <= side_s3;
			ps_s3[0] <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]};
			ps_s3[1] <= {1'b0, sq_s2[2]} + {1'b0, sq_s2[3]};
			ps_s3[2] <= {1'b0, sq_s2[4]} + {1'b0, sq_s2[5]};
			sum_s4   <= {1'b0, ps_s3[0]} + {1'b0, ps_s3[1]} + {1'b0, ps_s3[2]};
		end
	end

	logic        sq_v;
	logic [32:0] sq_root;
	side_t       sq_side;

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_sum    (sum_s4),
		.in_side   (side_s4),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	logic     dv_v;
	div_res_t dv_res;

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.in_len    (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_v),
		.out_res   (dv_res)
	);

	logic [NFIELD-1:0][DW-1:0] unit_q;
	logic [LW-1:0]             len_q;
	logic                      zero_q;
	logic                      is_zero;

	assign is_zero = dv_res.len == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v;
		end
	end

	for (genvar i = 0; i < NFIELD; i++) begin : g_out
		logic [QW-1:0] qc;
		logic [DW-1:0] qx;
		assign qc = (dv_res.quo[i] > ONE_Q30) ? ONE_Q30 : dv_res.quo[i];
		assign qx = {{(DW-QW){1'b0}}, qc};
		always_ff @(posedge clk) begin
			if (en) begin
				if (is_zero) begin
					unit_q[i] <= '0;
				end else begin
					unit_q[i] <= dv_res.neg[i] ? (~qx + 1'b1) : qx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_q  <= dv_res.len;
			zero_q <= is_zero;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = zero_q;
	assign m_tdata  = {7'b0, len_q, unit_q};

	`include "vector_normalize_assert.svh"

	`VN_ASSERT_IMP(a_zero_len, m_tvalid && m_tuser, len_q == '0)
	`VN_ASSERT_IMP(a_zero_unit, m_tvalid && m_tuser, unit_q == '0)
	`VN_ASSERT_IMP(a_len_nonzero, m_tvalid && !m_tuser, len_q != '0)
	`VN_ASSERT_NXT(a_enter, s_tvalid && s_tready, v_s1)
endmodule
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
module testbench;
	localparam int AXES  = 6;
	localparam int NAX   = 6;
	localparam int LIMIT = 600000;
	localparam logic [65:0] ONE_Q30 = 66'h40000000;

	typedef struct packed {
		logic [NAX-1:0][31:0] unit;
		logic [32:0]          len;
		logic                 zero;
	} norm_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [231:0] m_tdata;
	logic         m_tuser;

	norm_t expected_norms[$];
	int    errors = 0;
	int    cycles = 0;
	bit    idle_en = 1;
	int    stall_left = 0;

	vector_normalize #(.AXES(AXES)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic norm_t normalize(input logic [191:0] d);
		norm_t       r;
		logic [65:0] mag [NAX];
		logic        neg [NAX];
		logic [65:0] sum, root, cand, q;
		logic [31:0] v;
		sum = '0;
		for (int i = 0; i < NAX; i++) begin
			v = d[32*i +: 32];
			neg[i] = v[31] && i < AXES;
			mag[i] = (i >= AXES) ? 66'd0 : v[31] ? (66'h100000000 - v) : {34'd0, v};
			sum += mag[i] * mag[i];
		end
		r.zero = (sum == 0);
		root = '0;
		for (int b = 32; b >= 0; b--) begin
			cand = root | (66'd1 << b);
			if (cand * cand <= sum)
				root = cand;
		end
		r.len = r.zero ? 33'd0 : root[32:0];
		for (int i = 0; i < NAX; i++) begin
			q = '0;
			if (!r.zero && mag[i] != 0) begin
				q = (2 * mag[i] * ONE_Q30 + root) / (2 * root);
				if (q > ONE_Q30)
					q = ONE_Q30;
			end
			r.unit[i] = neg[i] ? (32'd0 - q[31:0]) : q[31:0];
		end
		return r;
	endfunction

	task automatic send_delta(input logic [191:0] d);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = d;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		expected_norms.push_back(normalize(d));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_axis(input int kind);
		case (kind)
			0: return $urandom();
			1: return $urandom_range(0, 255) - 128;
			2: return ($urandom_range(0, 1) ? 32'h0 : $urandom());
			default: return $signed($urandom()) >>> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic test_directed();
		logic [191:0] d;
		send_delta('0);
		send_delta({6{32'h80000000}});
		send_delta({6{32'h7fffffff}});
		send_delta({6{32'h80000001}});
		send_delta({6{32'hffffffff}});
		send_delta({6{32'h00000001}});
		for (int i = 0; i < NAX; i++) begin
			d = '0;
			d[32*i +: 32] = 32'h00010000;
			send_delta(d);
			d[32*i +: 32] = 32'h80000000;
			send_delta(d);
		end
		send_delta({32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h00000001, 32'hffffffff});
		send_delta({32'h0, 32'h0, 32'h0, 32'h0, 32'h00040000, 32'h00030000});
		send_delta({32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'h55555555, 32'haaaaaaaa, 32'h55555555});
	endtask

	task automatic test_random(input int n);
		logic [191:0] d;
		int kind;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(0, 3);
			for (int i = 0; i < NAX; i++)
				d[32*i +: 32] = rand_axis(kind);
			send_delta(d);
		end
	endtask

	task automatic test_back_to_back(input int n);
		idle_en = 0;
		test_random(n);
		s_tvalid = 0;
	endtask

	always @(negedge clk) begin
		if (!idle_en || !arst_n) begin
			m_tready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 17);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		norm_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_norms.size() == 0) begin
				$display("%0t: unexpected item %h user %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_norms.pop_front();
				for (int i = 0; i < NAX; i++)
					if (m_tdata[32*i +: 32] !== e.unit[i]) begin
						$display("%0t: unit_%0d expected %h actual %h", $time, i,
							e.unit[i], m_tdata[32*i +: 32]);
						errors++;
					end
				if (m_tdata[192 +: 33] !== e.len) begin
					$display("%0t: length expected %h actual %h", $time, e.len,
						m_tdata[192 +: 33]);
					errors++;
				end
				if (m_tuser !== e.zero) begin
					$display("%0t: zero_vector expected %b actual %b", $time, e.zero,
						m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("vector_normalize test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random(1000);
		test_back_to_back(130);
		while (expected_norms.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0 && expected_norms.size() == 0)
			$display("vector_normalize test passed");
		else
			$display("vector_normalize test failed");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/vn_pkg.sv
hw/rtl/vn_sqrt.sv
hw/rtl/vn_div.sv
hw/rtl/vector_normalize.sv
verif/testbench.sv
